// ===== rtl/afms_pkg.sv =====
// afms_pkg: shared widths, byte constants and types for the alternation search
// used by afms_match and alternation_first_match_search; no dependencies
`timescale 1ns / 1ps

package afms_pkg;

  localparam int POS_BITS = 16;
  localparam int CNT_W    = POS_BITS + 1;
  localparam int OFF_W    = 16;
  localparam int WIN_LEN  = 9;

  // first offset that is no longer stored or tested
  localparam logic [CNT_W-1:0] POS_LIMIT = CNT_W'(1) << POS_BITS;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_C = 8'h63;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_J = 8'h6a;
  localparam logic [7:0] CH_K = 8'h6b;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_O = 8'h6f;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  // pattern set codes
  localparam logic SET_NAMES  = 1'b0;
  localparam logic SET_DIGITS = 1'b1;

  // index 0 holds the newest byte
  typedef logic [WIN_LEN-1:0][7:0] win_t;

  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] start;
  } match_t;

endpackage

// ===== rtl/afms_match.sv =====
// afms_match: tests every branch of the selected alternation as ending at the
// newest window byte and returns the lowest start; depends on afms_pkg
`timescale 1ns / 1ps

module afms_match (
  input  afms_pkg::win_t                 win,
  input  logic [afms_pkg::CNT_W-1:0]     cnt,
  input  logic                           pattern_set,
  output afms_pkg::match_t               result
);

  logic fit3, fit4, fit5, fit9;
  logic m_fred, m_bob, m_janet, m_frederick, m_ted, m_digits;
  logic [4:0] is_digit;
  logic [3:0] len;

  assign fit3 = cnt >= afms_pkg::CNT_W'(3);
  assign fit4 = cnt >= afms_pkg::CNT_W'(4);
  assign fit5 = cnt >= afms_pkg::CNT_W'(5);
  assign fit9 = cnt >= afms_pkg::CNT_W'(9);

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      is_digit[i] = (win[i] >= afms_pkg::CH_0) && (win[i] <= afms_pkg::CH_9);
    end
  end

  // window index len-1 holds the first letter of a branch of length len
  assign m_bob = fit3 && win[2] == afms_pkg::CH_B && win[1] == afms_pkg::CH_O &&
                 win[0] == afms_pkg::CH_B;
  assign m_ted = fit3 && win[2] == afms_pkg::CH_T && win[1] == afms_pkg::CH_E &&
                 win[0] == afms_pkg::CH_D;
  assign m_fred = fit4 && win[3] == afms_pkg::CH_F && win[2] == afms_pkg::CH_R &&
                  win[1] == afms_pkg::CH_E && win[0] == afms_pkg::CH_D;
  assign m_janet = fit5 && win[4] == afms_pkg::CH_J && win[3] == afms_pkg::CH_A &&
                   win[2] == afms_pkg::CH_N && win[1] == afms_pkg::CH_E &&
                   win[0] == afms_pkg::CH_T;
  assign m_frederick = fit9 && win[8] == afms_pkg::CH_F && win[7] == afms_pkg::CH_R &&
                       win[6] == afms_pkg::CH_E && win[5] == afms_pkg::CH_D &&
                       win[4] == afms_pkg::CH_E && win[3] == afms_pkg::CH_R &&
                       win[2] == afms_pkg::CH_I && win[1] == afms_pkg::CH_C &&
                       win[0] == afms_pkg::CH_K;
  assign m_digits = fit5 && (&is_digit);

  // longest matching branch gives the lowest start for this end position
  always_comb begin
    len = 4'd0;
    unique case (pattern_set)
      afms_pkg::SET_NAMES: begin
        priority if (m_frederick) len = 4'd9;
        else if (m_janet)         len = 4'd5;
        else if (m_fred)          len = 4'd4;
        else if (m_bob)           len = 4'd3;
        else                      len = 4'd0;
      end
      afms_pkg::SET_DIGITS: begin
        priority if (m_digits)    len = 4'd5;
        else if (m_bob || m_ted)  len = 4'd3;
        else                      len = 4'd0;
      end
      default: len = 4'd0;
    endcase
  end

  logic [afms_pkg::CNT_W-1:0] start_full;
  assign start_full = cnt - afms_pkg::CNT_W'(len);

  assign result.hit   = len != 4'd0;
  assign result.start = start_full[afms_pkg::OFF_W-1:0];

endmodule

// ===== rtl/alternation_first_match_search.sv =====
// alternation_first_match_search: top level of the streaming alternation search
// holds input stage, window and stream state, result register; uses afms_pkg, afms_match
`timescale 1ns / 1ps

// Haystack bytes enter on data_byte/final_byte with data_valid/data_stall, one
// transaction per byte; the byte flagged final_byte closes the haystack.
// One result transaction (found, match_start) leaves on result_valid/result_stall
// for each haystack, holding the lowest start offset where any branch of the
// selected alternation matched (0 with found low when nothing matched).
// The user writes pattern_set through cfg_write_en/cfg_write_data only while idle;
// the block does not enforce this. Set 0 is fred|bob|janet|frederick, set 1 is
// bob|five digits|ted. Throughput: one byte per clock while data_stall is low. A byte
// goes through the input register, then one pass of window compares and a start-offset
// compare updates the stream state; a final byte's result is registered once the result
// register is free. Bytes beyond offset 65535 are not stored or tested.
// While a result waits on result_stall, bytes keep being accepted; only a
// second final byte holds in the input register, raising data_stall.
// Synchronous reset clears the stream state, both valid flags and pattern_set,
// and holds data_stall high; after a result the stream state clears.
module alternation_first_match_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        found,
  output logic [15:0] match_start
);

  logic                          pattern_set;
  logic                          s1_valid;
  logic [7:0]                    s1_byte;
  logic                          s1_final;
  afms_pkg::win_t                win;
  logic [afms_pkg::CNT_W-1:0]    bytes_seen;
  logic                          hit_seen;
  logic [afms_pkg::OFF_W-1:0]    hit_offset;

  logic                          s1_go;
  logic                          store;
  afms_pkg::win_t                win_shift;
  logic [afms_pkg::CNT_W-1:0]    cnt_inc;
  afms_pkg::match_t              m;
  logic                          take;
  logic                          hit_seen_next;
  logic [afms_pkg::OFF_W-1:0]    hit_offset_next;

  // a final byte needs a free result register before it can go
  assign s1_go      = s1_valid && (!s1_final || !result_valid || !result_stall);
  assign data_stall = rst || (s1_valid && !s1_go);

  assign store     = bytes_seen != afms_pkg::POS_LIMIT;
  assign win_shift = {win[afms_pkg::WIN_LEN-2:0], s1_byte};
  assign cnt_inc   = bytes_seen + afms_pkg::CNT_W'(1);

  afms_match u_match (
    .win         (win_shift),
    .cnt         (cnt_inc),
    .pattern_set (pattern_set),
    .result      (m)
  );

  assign take            = store && m.hit && (!hit_seen || m.start < hit_offset);
  assign hit_seen_next   = hit_seen || take;
  assign hit_offset_next = take ? m.start : hit_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_set  <= afms_pkg::SET_NAMES;
      s1_valid     <= 1'b0;
      win          <= '0;
      bytes_seen   <= '0;
      hit_seen     <= 1'b0;
      hit_offset   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        pattern_set <= cfg_write_data;
      end

      if (data_valid && !data_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go && s1_final) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (s1_go) begin
        if (s1_final) begin
          // haystack done: emit and start over
          win          <= '0;
          bytes_seen   <= '0;
          hit_seen     <= 1'b0;
          hit_offset   <= '0;
        end else if (store) begin
          win        <= win_shift;
          bytes_seen <= cnt_inc;
          hit_seen   <= hit_seen_next;
          hit_offset <= hit_offset_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      s1_byte  <= data_byte;
      s1_final <= final_byte;
    end
    if (s1_go && s1_final) begin
      found       <= hit_seen_next;
      match_start <= hit_seen_next ? hit_offset_next : '0;
    end
  end

endmodule
